@@ src/mib_pkg.sv @@
// ----------------------------------------------------------------------------
// mib_pkg
// Shared types and constants for the modular inverse / binomial block.
// ----------------------------------------------------------------------------
package mib_pkg;

  localparam int VAL_W = 31;   // operand, modulus and result width
  localparam int R_W   = 12;   // choose count width
  localparam int U_W   = 32;   // signed Euclid coefficient width
  localparam int CNT_W = 5;    // bit counter for the serial units

  localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EU_CHECK,
    S_EU_WAIT,
    S_RED,
    S_RED_WAIT,
    S_MUL_A,
    S_MUL_A_WAIT,
    S_INV_INIT,
    S_MUL_B_WAIT,
    S_LOOP,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INV_INIT_OP,
    CMD_INV_INIT_I,
    CMD_DIV_EU,
    CMD_EU_UPDATE,
    CMD_RED_START,
    CMD_MUL_RED,
    CMD_MUL_INV,
    CMD_BIN_INIT,
    CMD_NEXT_I,
    CMD_RES_INV,
    CMD_RES_ZERO,
    CMD_RES_ONE,
    CMD_RES_ACC
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic m_small;
    logic r_zero;
    logic r_bad;
    logic b_zero;
    logic i_done;
    logic div_done;
    logic mul_done;
  } status_t;

endpackage

@@ src/mib_div.sv @@
// ----------------------------------------------------------------------------
// mib_div
// Restoring divider, one quotient bit per cycle. Alongside the quotient it
// accumulates quotient * mult (mod 2^32) for the Euclid coefficient update.
// ----------------------------------------------------------------------------
module mib_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mib_pkg::VAL_W-1:0]      dividend,
  input  logic [mib_pkg::VAL_W-1:0]      divisor,
  input  logic [mib_pkg::U_W-1:0]        mult,
  output logic                           done,
  output logic [mib_pkg::VAL_W-1:0]      rem,
  output logic [mib_pkg::U_W-1:0]        prod
);

  logic                         busy;
  logic [mib_pkg::CNT_W-1:0]    cnt;
  logic [mib_pkg::VAL_W-1:0]    dvd;
  logic [mib_pkg::VAL_W-1:0]    dsr;
  logic [mib_pkg::U_W-1:0]      mult_q;
  logic [mib_pkg::VAL_W:0]      rsh;
  logic [mib_pkg::VAL_W:0]      diff;
  logic                         ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    rsh  = {rem, dvd[mib_pkg::VAL_W-1]};
    diff = rsh - {1'b0, dsr};
    ge   = (rsh >= {1'b0, dsr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mib_pkg::CNT_W'(mib_pkg::VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd    <= dividend;
      dsr    <= divisor;
      mult_q <= mult;
      rem    <= '0;
      prod   <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[mib_pkg::VAL_W-1:0] : rsh[mib_pkg::VAL_W-1:0];
      dvd  <= {dvd[mib_pkg::VAL_W-2:0], 1'b0};
      prod <= {prod[mib_pkg::U_W-2:0], 1'b0} + (ge ? mult_q : '0);
    end
  end

endmodule

@@ src/mib_dp.sv @@
// ----------------------------------------------------------------------------
// mib_dp
// Datapath: modulus register, item registers, Euclid state, modular
// multiplier (bit serial, doubling then adding per bit) and the result register.
// ----------------------------------------------------------------------------
module mib_dp #(
  parameter int MAX_CHOOSE = 4095
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mib_pkg::cmd_t               cmd,
  input  logic                        modulus_we,
  input  logic [mib_pkg::VAL_W-1:0]   modulus_data,
  input  logic                        mode,
  input  logic [mib_pkg::VAL_W-1:0]   operand,
  input  logic [mib_pkg::R_W-1:0]     choose_count,
  output mib_pkg::status_t            status,
  output logic [mib_pkg::VAL_W-1:0]   res
);

  localparam int MC_W = 16;

  logic [mib_pkg::VAL_W-1:0] m;
  logic                      mode_q;
  logic [mib_pkg::VAL_W-1:0] n_q;
  logic [mib_pkg::R_W-1:0]   r_q;
  logic [mib_pkg::R_W-1:0]   i;
  logic [mib_pkg::VAL_W-1:0] acc;
  logic [mib_pkg::VAL_W-1:0] a;
  logic [mib_pkg::VAL_W-1:0] b;
  logic [mib_pkg::U_W-1:0]   u;
  logic [mib_pkg::U_W-1:0]   v;
  logic [mib_pkg::VAL_W-1:0] u_norm;

  logic                      div_start;
  logic [mib_pkg::VAL_W-1:0] div_dvd;
  logic [mib_pkg::VAL_W-1:0] div_dsr;
  logic [mib_pkg::U_W-1:0]   div_mult;
  logic                      div_done;
  logic [mib_pkg::VAL_W-1:0] div_rem;
  logic [mib_pkg::U_W-1:0]   div_prod;

  logic                      mul_busy;
  logic                      mul_done;
  logic                      mul_phase;
  logic [mib_pkg::CNT_W-1:0] mul_cnt;
  logic [mib_pkg::VAL_W-1:0] mp;
  logic [mib_pkg::VAL_W-1:0] mx;
  logic [mib_pkg::VAL_W:0]   mp_sum;
  logic [mib_pkg::VAL_W:0]   mp_red;
  logic [mib_pkg::U_W-1:0]   m_ext;

  // Euclid coefficient folded into 0..m-1
  always_comb begin
    m_ext = {1'b0, m};
    if (u == m_ext || u == -m_ext) begin
      u_norm = '0;
    end else if (u[mib_pkg::U_W-1]) begin
      u_norm = mib_pkg::VAL_W'(u + m_ext);
    end else begin
      u_norm = u[mib_pkg::VAL_W-1:0];
    end
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = a;
    div_dsr   = b;
    div_mult  = v;
    unique case (cmd)
      mib_pkg::CMD_DIV_EU: begin
        div_start = 1'b1;
      end
      mib_pkg::CMD_RED_START: begin
        div_start = 1'b1;
        div_dvd   = n_q - {{(mib_pkg::VAL_W - mib_pkg::R_W){1'b0}}, i};
        div_dsr   = m;
        div_mult  = '0;
      end
      default: begin
      end
    endcase
  end

  mib_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .mult     (div_mult),
    .done     (div_done),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      m <= mib_pkg::MODULUS_RESET;
    end else if (modulus_we) begin
      m <= modulus_data;
    end
  end

  // item, Euclid and result registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      mib_pkg::CMD_LOAD: begin
        mode_q <= mode;
        n_q    <= operand;
        r_q    <= choose_count;
      end
      mib_pkg::CMD_INV_INIT_OP: begin
        a <= n_q;
        b <= m;
        u <= mib_pkg::U_W'(1);
        v <= '0;
      end
      mib_pkg::CMD_INV_INIT_I: begin
        a <= mib_pkg::VAL_W'(i) + 1'b1;
        b <= m;
        u <= mib_pkg::U_W'(1);
        v <= '0;
      end
      mib_pkg::CMD_EU_UPDATE: begin
        a <= b;
        b <= div_rem;
        u <= v;
        v <= u - div_prod;
      end
      mib_pkg::CMD_BIN_INIT: begin
        i   <= '0;
        acc <= mib_pkg::VAL_W'(1);
      end
      mib_pkg::CMD_NEXT_I: begin
        i <= i + 1'b1;
      end
      mib_pkg::CMD_RES_INV:  res <= u_norm;
      mib_pkg::CMD_RES_ZERO: res <= '0;
      mib_pkg::CMD_RES_ONE:  res <= mib_pkg::VAL_W'(1);
      mib_pkg::CMD_RES_ACC:  res <= acc;
      default: begin
      end
    endcase
    if (mul_done) begin
      acc <= mp;
    end
  end

  // modular multiply step: double on phase 0, add on phase 1
  always_comb begin
    if (!mul_phase) begin
      mp_sum = {mp, 1'b0};
    end else begin
      mp_sum = {1'b0, mp} + (mx[mib_pkg::VAL_W-1] ? {1'b0, acc} : '0);
    end
    mp_red = (mp_sum >= {1'b0, m}) ? mp_sum - {1'b0, m} : mp_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy  <= 1'b0;
      mul_done  <= 1'b0;
      mul_phase <= 1'b0;
      mul_cnt   <= '0;
    end else begin
      mul_done <= 1'b0;
      if (cmd == mib_pkg::CMD_MUL_RED || cmd == mib_pkg::CMD_MUL_INV) begin
        mul_busy  <= 1'b1;
        mul_phase <= 1'b0;
        mul_cnt   <= '0;
      end else if (mul_busy) begin
        mul_phase <= ~mul_phase;
        if (mul_phase) begin
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == mib_pkg::CNT_W'(mib_pkg::VAL_W - 1)) begin
            mul_busy <= 1'b0;
            mul_done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == mib_pkg::CMD_MUL_RED || cmd == mib_pkg::CMD_MUL_INV) begin
      mp <= '0;
      mx <= (cmd == mib_pkg::CMD_MUL_RED) ? div_rem : u_norm;
    end else if (mul_busy) begin
      mp <= mp_red[mib_pkg::VAL_W-1:0];
      if (mul_phase) begin
        mx <= {mx[mib_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

  // status to the controller
  always_comb begin
    status.mode     = mode_q;
    status.m_small  = (m < mib_pkg::VAL_W'(2));
    status.r_zero   = (r_q == '0);
    status.r_bad    = ({{(mib_pkg::VAL_W - mib_pkg::R_W){1'b0}}, r_q} > n_q) ||
                      (MC_W'(r_q) > MC_W'(MAX_CHOOSE));
    status.b_zero   = (b == '0);
    status.i_done   = (i == r_q);
    status.div_done = div_done;
    status.mul_done = mul_done;
  end

endmodule

@@ src/mib_ctrl.sv @@
// ----------------------------------------------------------------------------
// mib_ctrl
// Sequencer: steps the datapath through the Euclid loop, the reductions and
// the modular products of one request.
// ----------------------------------------------------------------------------
module mib_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  mib_pkg::status_t  status,
  output logic              in_ready,
  output logic              out_load,
  output mib_pkg::cmd_t     cmd
);

  mib_pkg::state_t state;
  mib_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mib_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = mib_pkg::CMD_NONE;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      mib_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = mib_pkg::CMD_LOAD;
          state_next = mib_pkg::S_DISPATCH;
        end
      end
      mib_pkg::S_DISPATCH: begin
        priority if (status.m_small) begin
          cmd        = mib_pkg::CMD_RES_ZERO;
          state_next = mib_pkg::S_DONE;
        end else if (!status.mode) begin
          cmd        = mib_pkg::CMD_INV_INIT_OP;
          state_next = mib_pkg::S_EU_CHECK;
        end else if (status.r_zero) begin
          cmd        = mib_pkg::CMD_RES_ONE;
          state_next = mib_pkg::S_DONE;
        end else if (status.r_bad) begin
          cmd        = mib_pkg::CMD_RES_ZERO;
          state_next = mib_pkg::S_DONE;
        end else begin
          cmd        = mib_pkg::CMD_BIN_INIT;
          state_next = mib_pkg::S_RED;
        end
      end
      mib_pkg::S_EU_CHECK: begin
        priority if (!status.b_zero) begin
          cmd        = mib_pkg::CMD_DIV_EU;
          state_next = mib_pkg::S_EU_WAIT;
        end else if (!status.mode) begin
          cmd        = mib_pkg::CMD_RES_INV;
          state_next = mib_pkg::S_DONE;
        end else begin
          cmd        = mib_pkg::CMD_MUL_INV;
          state_next = mib_pkg::S_MUL_B_WAIT;
        end
      end
      mib_pkg::S_EU_WAIT: begin
        if (status.div_done) begin
          cmd        = mib_pkg::CMD_EU_UPDATE;
          state_next = mib_pkg::S_EU_CHECK;
        end
      end
      mib_pkg::S_RED: begin
        cmd        = mib_pkg::CMD_RED_START;
        state_next = mib_pkg::S_RED_WAIT;
      end
      mib_pkg::S_RED_WAIT: begin
        if (status.div_done) begin
          state_next = mib_pkg::S_MUL_A;
        end
      end
      mib_pkg::S_MUL_A: begin
        cmd        = mib_pkg::CMD_MUL_RED;
        state_next = mib_pkg::S_MUL_A_WAIT;
      end
      mib_pkg::S_MUL_A_WAIT: begin
        if (status.mul_done) begin
          state_next = mib_pkg::S_INV_INIT;
        end
      end
      mib_pkg::S_INV_INIT: begin
        cmd        = mib_pkg::CMD_INV_INIT_I;
        state_next = mib_pkg::S_EU_CHECK;
      end
      mib_pkg::S_MUL_B_WAIT: begin
        if (status.mul_done) begin
          cmd        = mib_pkg::CMD_NEXT_I;
          state_next = mib_pkg::S_LOOP;
        end
      end
      mib_pkg::S_LOOP: begin
        if (status.i_done) begin
          cmd        = mib_pkg::CMD_RES_ACC;
          state_next = mib_pkg::S_DONE;
        end else begin
          state_next = mib_pkg::S_RED;
        end
      end
      mib_pkg::S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = mib_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mib_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/modular_inverse_and_binomial.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_and_binomial
// Modular inverse (extended Euclid) or C(n, r) mod a configured modulus.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------
//  in        | in_valid / in_ready  | mode, operand, choose_count
//  out       | out_valid / out_ready| result
//  config    | modulus_we           | modulus_data
//
//  One request at a time. A Euclid step is a 31-bit serial divide plus an
//  update. Binomial: r rounds, each reducing n - i mod m, multiplying it in,
//  inverting i + 1 and multiplying by the inverse, using the serial divider
//  and the bit-serial modular multiplier. Synchronous reset restores
//  modulus 1000000007. A new request is taken while a result waits on out.
// ----------------------------------------------------------------------------
module modular_inverse_and_binomial #(
  parameter int MAX_CHOOSE = 4095
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [mib_pkg::VAL_W-1:0]   operand,
  input  logic [mib_pkg::R_W-1:0]     choose_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mib_pkg::VAL_W-1:0]   result,
  input  logic                        modulus_we,
  input  logic [mib_pkg::VAL_W-1:0]   modulus_data
);

  mib_pkg::cmd_t             cmd;
  mib_pkg::status_t          status;
  logic                      out_load;
  logic                      out_free;
  logic [mib_pkg::VAL_W-1:0] res;

  assign out_free = !out_valid || out_ready;

  mib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  mib_dp #(
    .MAX_CHOOSE (MAX_CHOOSE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .modulus_we   (modulus_we),
    .modulus_data (modulus_data),
    .mode         (mode),
    .operand      (operand),
    .choose_count (choose_count),
    .status       (status),
    .res          (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= res;
    end
  end

endmodule

@@ src/mib_checker.sv @@
// ----------------------------------------------------------------------------
// mib_checker
// Port-level checks for the modular inverse / binomial block.
// ----------------------------------------------------------------------------
module mib_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mib_pkg::VAL_W-1:0]   result
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  // drop ready after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // result lies below the largest legal modulus, 2^31 - 1
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result != {mib_pkg::VAL_W{1'b1}})
    else $error("result out of range");

endmodule

bind modular_inverse_and_binomial mib_checker u_mib_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .result    (result)
);
